### design/amf_pkg.sv
// ----------------------------------------------------------------------------
// amf_pkg: shared types and constants of the wrap-aware median angle filter
// Sample link between sort cells, angle constants and register indexes.
// ----------------------------------------------------------------------------
package amf_pkg;

    localparam int ANGLE_W = 14;
    localparam int SUM_W   = 17;

    // one full turn of the angle code
    localparam logic [ANGLE_W:0] PERIOD = 15'd16384;

    // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT for any x below 2^17
    localparam logic [SUM_W-1:0] DIV3_MUL   = 17'd43691;
    localparam int               DIV3_SHIFT = 17;

    // register indexes (byte address / 4)
    localparam logic REG_MEDIAN_EN  = 1'b0;
    localparam logic REG_SAMPLE_CNT = 1'b1;

    typedef struct packed {
        logic               vld;
        logic [ANGLE_W-1:0] val;
    } amf_link_t;

endpackage

### design/amf_cell.sv
// ----------------------------------------------------------------------------
// amf_cell: one insertion-sort cell
// Keeps the smallest value seen since clear and hands the larger one on.
// ----------------------------------------------------------------------------
module amf_cell
    import amf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      clr,
    input  amf_link_t in_link,
    output amf_link_t out_link,
    output amf_link_t held
);

    amf_link_t hold_reg, hold_next;
    amf_link_t out_reg, out_next;

    always_comb begin
        hold_next    = hold_reg;
        out_next     = in_link;
        out_next.vld = 1'b0;
        if (in_link.vld) begin
            if (!hold_reg.vld) begin
                hold_next = in_link;
            end else if (in_link.val < hold_reg.val) begin
                hold_next = in_link;
                out_next  = hold_reg;
            end else begin
                out_next = in_link;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            hold_reg <= '0;
            out_reg  <= '0;
        end else begin
            hold_reg <= hold_next;
            out_reg  <= out_next;
        end
    end

    assign out_link = out_reg;
    assign held     = hold_reg;

endmodule

### design/wrap_aware_median_angle_filter.sv
// ----------------------------------------------------------------------------
// wrap_aware_median_angle_filter: median of N angle samples across the wrap
// Error replies count toward an abort; good samples fill a batch that is
// sorted through a chain of cells, gap-scanned and averaged at its middle.
// ----------------------------------------------------------------------------
// A beat that finishes a batch of N starts N store reads into the cell chain,
// then chain drain, an N-step gap scan, up to 3 middle reads and a divide
// before its result is offered. An abort goes straight to its result.
// Reset (synchronous, aresetn low): counts cleared, registers to defaults
// (median off, N = 1); the sample store is not cleared.
module wrap_aware_median_angle_filter
    import amf_pkg::*;
#(
    parameter int MAX_SAMPLES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] response_word
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [13:0] filtered_angle, [15:14] zero
    output logic [0:0]  m_tuser,   // [0] batch_failed
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_SAMPLES);

    typedef enum logic [2:0] {
        ST_IDLE, ST_FEED, ST_DRAIN, ST_GAP, ST_AVG, ST_DIV, ST_RES
    } state_t;

    state_t state_reg;

    logic               med_en_reg;
    logic [4:0]         cnt_cfg_reg;
    logic [CW-1:0]      good_cnt_reg, err_cnt_reg, n_reg, k_reg, cut_reg, j_reg;
    logic [1:0]         rem_reg;
    logic [ANGLE_W-1:0] prev_reg, widest_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [ANGLE_W-1:0] res_angle_reg;
    logic               res_fail_reg;
    logic               m_valid_reg;
    logic [ANGLE_W-1:0] m_angle_reg;
    logic               m_fail_reg;
    logic               feed_vld_reg;
    logic [ANGLE_W-1:0] feed_val_reg;

    logic [ANGLE_W-1:0] store_mem [MAX_SAMPLES];

    // ---------------- configuration port ----------------
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_MEDIAN_EN:  prdata = {31'd0, med_en_reg};
            REG_SAMPLE_CNT: prdata = {27'd0, cnt_cfg_reg};
            default:        prdata = '0;
        endcase
    end

    // effective batch size
    logic [CW-1:0] bsize;
    always_comb begin
        if (!med_en_reg || cnt_cfg_reg == 5'd0) begin
            bsize = CW'(1);
        end else if (7'(cnt_cfg_reg) > 7'(MAX_SAMPLES)) begin
            bsize = MAX_N;
        end else begin
            bsize = CW'(cnt_cfg_reg);
        end
    end

    // ---------------- sort chain ----------------
    amf_link_t          link [MAX_SAMPLES+1];
    amf_link_t          held [MAX_SAMPLES];
    logic [ANGLE_W-1:0] cell_val [MAX_SAMPLES];
    logic               clr;

    assign link[0] = '{vld: feed_vld_reg, val: feed_val_reg};

    for (genvar c = 0; c < MAX_SAMPLES; c++) begin : g_cell
        amf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clr      (clr),
            .in_link  (link[c]),
            .out_link (link[c+1]),
            .held     (held[c])
        );
        assign cell_val[c] = held[c].val;
    end

    // ---------------- datapath helpers ----------------
    logic                in_acc, in_err, in_done;
    logic [CW-1:0]       good_inc;
    logic [ANGLE_W-1:0]  gap_v, gap_d;
    logic [CW:0]         tidx;
    logic                twrap;
    logic [IW-1:0]       ridx;
    logic [ANGLE_W-1:0]  avg_v;
    logic [ANGLE_W:0]    avg_w;
    logic [CW-1:0]       half;
    logic [2*SUM_W-1:0]  prod3;
    logic [SUM_W-1:0]    quot;

    assign in_acc   = s_tvalid && s_tready;
    assign in_err   = s_tdata[14];
    assign good_inc = good_cnt_reg + CW'(1);
    assign in_done  = in_acc && !in_err && (good_inc >= bsize);
    assign clr      = in_done;

    assign gap_v = cell_val[k_reg[IW-1:0]];
    assign gap_d = gap_v - prev_reg;

    // rotated read: sample below the widest gap moves up one period
    assign tidx  = (CW+1)'(cut_reg) + (CW+1)'(j_reg);
    assign twrap = widest_reg[ANGLE_W-1] && (tidx >= (CW+1)'(n_reg));
    always_comb begin
        if (!widest_reg[ANGLE_W-1]) begin
            ridx = j_reg[IW-1:0];
        end else if (twrap) begin
            ridx = IW'(tidx - (CW+1)'(n_reg));
        end else begin
            ridx = IW'(tidx);
        end
    end
    assign avg_v = cell_val[ridx];
    assign avg_w = {1'b0, avg_v} + (twrap ? PERIOD : '0);

    assign half  = n_reg >> 1;
    assign prod3 = 34'(sum_reg) * 34'(DIV3_MUL);
    always_comb begin
        if (n_reg == CW'(1)) begin
            quot = sum_reg;
        end else if (n_reg[0]) begin
            quot = SUM_W'(prod3 >> DIV3_SHIFT);
        end else begin
            quot = sum_reg >> 1;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // ---------------- sample store ----------------
    always_ff @(posedge aclk) begin
        if (in_acc && !in_err) begin
            store_mem[good_cnt_reg[IW-1:0]] <= s_tdata[ANGLE_W-1:0];
        end
        feed_val_reg <= store_mem[k_reg[IW-1:0]];
    end

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            med_en_reg   <= 1'b0;
            cnt_cfg_reg  <= 5'd1;
            good_cnt_reg <= '0;
            err_cnt_reg  <= '0;
            n_reg        <= CW'(1);
            k_reg        <= '0;
            cut_reg      <= '0;
            j_reg        <= '0;
            rem_reg      <= '0;
            widest_reg   <= '0;
            feed_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            res_fail_reg <= 1'b0;
        end else begin
            feed_vld_reg <= (state_reg == ST_FEED);
            if (cfg_we) begin
                unique case (paddr[2])
                    REG_MEDIAN_EN:  med_en_reg  <= pwdata[0];
                    REG_SAMPLE_CNT: cnt_cfg_reg <= pwdata[4:0];
                    default:        ;
                endcase
            end
            // a result waiting in ST_RES reloads the output itself
            if (m_valid_reg && m_tready && state_reg != ST_RES) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (in_err) begin
                            if (err_cnt_reg >= bsize) begin
                                res_angle_reg <= '0;
                                res_fail_reg  <= 1'b1;
                                good_cnt_reg  <= '0;
                                err_cnt_reg   <= '0;
                                state_reg     <= ST_RES;
                            end else begin
                                err_cnt_reg <= err_cnt_reg + CW'(1);
                            end
                        end else if (in_done) begin
                            n_reg        <= bsize;
                            good_cnt_reg <= '0;
                            err_cnt_reg  <= '0;
                            k_reg        <= '0;
                            widest_reg   <= '0;
                            cut_reg      <= '0;
                            state_reg    <= ST_FEED;
                        end else begin
                            good_cnt_reg <= good_inc;
                        end
                    end
                end
                ST_FEED: begin
                    if (k_reg == n_reg - CW'(1)) begin
                        k_reg     <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + CW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (k_reg == MAX_N) begin
                        k_reg     <= '0;
                        state_reg <= ST_GAP;
                    end else begin
                        k_reg <= k_reg + CW'(1);
                    end
                end
                ST_GAP: begin
                    prev_reg <= gap_v;
                    if (k_reg != '0 && gap_d > widest_reg) begin
                        widest_reg <= gap_d;
                        cut_reg    <= k_reg;
                    end
                    if (k_reg == n_reg - CW'(1)) begin
                        sum_reg   <= '0;
                        state_reg <= ST_AVG;
                        if (n_reg == CW'(1)) begin
                            j_reg   <= '0;
                            rem_reg <= 2'd1;
                        end else begin
                            j_reg   <= half - CW'(1);
                            rem_reg <= n_reg[0] ? 2'd3 : 2'd2;
                        end
                    end else begin
                        k_reg <= k_reg + CW'(1);
                    end
                end
                ST_AVG: begin
                    sum_reg <= sum_reg + SUM_W'(avg_w);
                    j_reg   <= j_reg + CW'(1);
                    rem_reg <= rem_reg - 2'd1;
                    if (rem_reg == 2'd1) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    res_angle_reg <= quot[ANGLE_W-1:0];
                    res_fail_reg  <= 1'b0;
                    state_reg     <= ST_RES;
                end
                ST_RES: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_angle_reg <= res_angle_reg;
                        m_fail_reg  <= res_fail_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_angle_reg};
    assign m_tuser  = m_fail_reg;

`ifndef SYNTH
    a_good_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        good_cnt_reg < MAX_N)
        else $error("good sample count out of range");

    a_err_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        err_cnt_reg <= MAX_N)
        else $error("error count out of range");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("failed batch with nonzero angle");

    a_clr_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        clr |=> (state_reg == ST_FEED))
        else $error("chain cleared without a feed");
`endif

endmodule
